/* hdl/i2c_target_byte_engine_macros.svh */
// Assertion macros shared by the I2C target byte engine RTL.
// Defining ASSERT_OFF compiles every check away to nothing.
`ifndef I2C_TARGET_BYTE_ENGINE_MACROS_SVH
`define I2C_TARGET_BYTE_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge, suspended while reset is low.
`define I2C_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define I2C_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define I2C_ASSERT(lbl, clk, rst_n, prop, msg)
`define I2C_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* hdl/i2c_tbe_pkg.sv */
// Shared types, codes and reset constants of the I2C target byte engine.
// No dependencies; every module file of the engine imports this package.
`timescale 1ns / 1ps

package i2c_tbe_pkg;

  // Register reset values
  localparam logic [6:0] OWN_ADDRESS_RST   = 7'h57;
  localparam logic [7:0] RX_BYTE_COUNT_RST = 8'd1;
  localparam logic [7:0] TX_BYTE_COUNT_RST = 8'd1;
  localparam logic [7:0] TX_DATA_RST       = 8'h55;

  // Result queue depth default
  localparam int unsigned OUTQ_DEPTH = 2;

  // Bits per byte on the bus
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [7:0] {
    CFG_OWN_ADDRESS   = 8'd0,
    CFG_RX_BYTE_COUNT = 8'd1,
    CFG_TX_BYTE_COUNT = 8'd2,
    CFG_TX_DATA       = 8'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_ADDR      = 3'd1,
    PH_ADDR_ACK  = 3'd2,
    PH_WRITE     = 3'd3,
    PH_WRITE_ACK = 3'd4,
    PH_READ      = 3'd5,
    PH_READ_ACK  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_WRITE = 3'd1,
    EV_READ  = 3'd2,
    EV_WRONG = 3'd3,
    EV_DONE  = 3'd4
  } event_e;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
  } in_t;

  typedef struct packed {
    logic       sda_pull_low;
    logic       rx_valid;
    logic [7:0] rx_byte;
    event_e     event_code;
  } out_t;

  typedef struct packed {
    logic [6:0] own_address;
    logic [7:0] rx_byte_count;
    logic [7:0] tx_byte_count;
    logic [7:0] tx_data;
  } cfg_t;

endpackage

/* hdl/i2c_tbe_cfg.sv */
// Configuration register file of the I2C target byte engine.
// Depends on i2c_tbe_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module i2c_tbe_cfg import i2c_tbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  logic [7:0] wr_index_i,
  input  logic [7:0] wr_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_d, cfg_q;

  // Decode the write index; unknown indexes leave everything unchanged
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_OWN_ADDRESS:   cfg_d.own_address   = wr_data_i[6:0];
        CFG_RX_BYTE_COUNT: cfg_d.rx_byte_count = wr_data_i;
        CFG_TX_BYTE_COUNT: cfg_d.tx_byte_count = wr_data_i;
        CFG_TX_DATA:       cfg_d.tx_data       = wr_data_i;
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address   <= OWN_ADDRESS_RST;
      cfg_q.rx_byte_count <= RX_BYTE_COUNT_RST;
      cfg_q.tx_byte_count <= TX_BYTE_COUNT_RST;
      cfg_q.tx_data       <= TX_DATA_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/i2c_tbe_core.sv */
// Bus-tracking state machine of the I2C target byte engine: edge and start
// detection, address match, byte receive and transmit. Uses i2c_tbe_pkg.
`timescale 1ns / 1ps

`include "i2c_target_byte_engine_macros.svh"

module i2c_tbe_core import i2c_tbe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  in_t  sample_i,
  input  cfg_t cfg_i,
  output out_t result_o
);

  phase_e     phase_d, phase_q;
  logic       prev_scl_q, prev_sda_q;
  logic [3:0] bit_count_d, bit_count_q;
  logic [7:0] shift_d, shift_q;
  logic [7:0] byte_count_d, byte_count_q;
  logic       drive_low_d, drive_low_q;

  logic       rise, fall, start_cond;
  logic [7:0] shifted;
  logic [3:0] bit_inc;
  logic [7:0] byte_inc;
  logic       rx_valid;
  logic [7:0] rx_byte;
  event_e     event_code;

  // Line edges and start condition against the previous sample
  assign rise       = sample_i.scl_level & ~prev_scl_q;
  assign fall       = ~sample_i.scl_level & prev_scl_q;
  assign start_cond = sample_i.scl_level & prev_scl_q & prev_sda_q & ~sample_i.sda_level;
  assign shifted    = {shift_q[6:0], sample_i.sda_level};
  assign bit_inc    = bit_count_q + 4'd1;
  assign byte_inc   = byte_count_q + 8'd1;

  // Next state
  always_comb begin
    phase_d      = phase_q;
    bit_count_d  = bit_count_q;
    shift_d      = shift_q;
    byte_count_d = byte_count_q;
    drive_low_d  = drive_low_q;
    if (start_cond) begin
      phase_d      = PH_ADDR;
      bit_count_d  = '0;
      shift_d      = '0;
      byte_count_d = '0;
      drive_low_d  = 1'b0;
    end else begin
      unique case (phase_q)
        PH_ADDR: begin
          if (rise) begin
            shift_d     = shifted;
            bit_count_d = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) begin
              phase_d     = (shifted[7:1] == cfg_i.own_address) ? PH_ADDR_ACK : PH_IDLE;
              bit_count_d = '0;
            end
          end
        end
        PH_ADDR_ACK: begin
          if (fall) begin
            if (!drive_low_q) begin
              drive_low_d = 1'b1;
            end else if (shift_q[0]) begin
              // Load the first transmit byte and put its MSB on the line
              shift_d     = cfg_i.tx_data;
              drive_low_d = ~cfg_i.tx_data[7];
              bit_count_d = 4'd1;
              phase_d     = PH_READ;
            end else begin
              drive_low_d = 1'b0;
              bit_count_d = '0;
              shift_d     = '0;
              phase_d     = PH_WRITE;
            end
          end
        end
        PH_WRITE: begin
          if (rise) begin
            shift_d     = shifted;
            bit_count_d = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) begin
              bit_count_d = '0;
              phase_d     = PH_WRITE_ACK;
            end
          end
        end
        PH_WRITE_ACK: begin
          if (fall) begin
            if (!drive_low_q) begin
              drive_low_d = 1'b1;
            end else begin
              drive_low_d  = 1'b0;
              byte_count_d = byte_inc;
              if (byte_inc == cfg_i.rx_byte_count) begin
                phase_d = PH_IDLE;
              end else begin
                bit_count_d = '0;
                shift_d     = '0;
                phase_d     = PH_WRITE;
              end
            end
          end
        end
        PH_READ: begin
          if (fall) begin
            if (bit_count_q < BITS_PER_BYTE) begin
              // Bit index 7 - count is the inverse of the low three count bits
              drive_low_d = ~shift_q[~bit_count_q[2:0]];
              bit_count_d = bit_inc;
            end else begin
              drive_low_d = 1'b0;
              bit_count_d = '0;
              phase_d     = PH_READ_ACK;
            end
          end
        end
        PH_READ_ACK: begin
          if (fall) begin
            byte_count_d = byte_inc;
            if (byte_inc == cfg_i.tx_byte_count) begin
              drive_low_d = 1'b0;
              phase_d     = PH_IDLE;
            end else begin
              shift_d     = cfg_i.tx_data;
              drive_low_d = ~cfg_i.tx_data[7];
              bit_count_d = 4'd1;
              phase_d     = PH_READ;
            end
          end
        end
        default: begin
          phase_d     = PH_IDLE;
          drive_low_d = 1'b0;
        end
      endcase
    end
  end

  // Result outputs: received byte and event flags
  always_comb begin
    rx_valid   = 1'b0;
    rx_byte    = '0;
    event_code = EV_NONE;
    if (!start_cond) begin
      unique case (phase_q)
        PH_ADDR: begin
          if (rise && bit_inc >= BITS_PER_BYTE) begin
            if (shifted[7:1] == cfg_i.own_address) begin
              event_code = shifted[0] ? EV_READ : EV_WRITE;
            end else begin
              event_code = EV_WRONG;
            end
          end
        end
        PH_WRITE: begin
          if (rise && bit_inc >= BITS_PER_BYTE) begin
            rx_valid = 1'b1;
            rx_byte  = shifted;
          end
        end
        PH_WRITE_ACK: begin
          if (fall && drive_low_q && byte_inc == cfg_i.rx_byte_count) begin
            event_code = EV_DONE;
          end
        end
        PH_READ_ACK: begin
          if (fall && byte_inc == cfg_i.tx_byte_count) begin
            event_code = EV_DONE;
          end
        end
        default: begin
          event_code = EV_NONE;
        end
      endcase
    end
  end

  assign result_o.sda_pull_low = drive_low_d;
  assign result_o.rx_valid     = rx_valid;
  assign result_o.rx_byte      = rx_byte;
  assign result_o.event_code   = event_code;

  // Advance bus state on each accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      prev_scl_q   <= 1'b1;
      prev_sda_q   <= 1'b1;
      bit_count_q  <= '0;
      shift_q      <= '0;
      byte_count_q <= '0;
      drive_low_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      prev_scl_q   <= sample_i.scl_level;
      prev_sda_q   <= sample_i.sda_level;
      bit_count_q  <= bit_count_d;
      shift_q      <= shift_d;
      byte_count_q <= byte_count_d;
      drive_low_q  <= drive_low_d;
    end
  end

  // SDA is only pulled low during an acknowledge or a transmitted byte
  `I2C_ASSERT(a_drive_phase, clk_i, rst_ni, drive_low_q |-> (phase_q == PH_ADDR_ACK || phase_q == PH_WRITE_ACK || phase_q == PH_READ), "SDA driven outside ACK or read phase")
  // A received byte only completes while receiving write data
  `I2C_ASSERT(a_rx_phase, clk_i, rst_ni, result_o.rx_valid |-> (phase_q == PH_WRITE && !start_cond), "rx byte outside write phase")
  // An accepted start restarts address reception with cleared counters
  `I2C_ASSERT(a_start_restart, clk_i, rst_ni, (accept_i && start_cond) |=> (phase_q == PH_ADDR && bit_count_q == 4'd0 && byte_count_q == 8'd0 && !drive_low_q), "start did not restart transfer")

endmodule

/* hdl/i2c_tbe_outq.sv */
// Result queue of the I2C target byte engine; lets a new sample enter while
// an earlier result waits on a stalled output. Uses i2c_tbe_pkg for out_t.
`timescale 1ns / 1ps

`include "i2c_target_byte_engine_macros.svh"

module i2c_tbe_outq import i2c_tbe_pkg::*; #(
  parameter int unsigned Depth = OUTQ_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  out_t push_data_i,
  output logic full_o,
  output logic valid_o,
  input  logic stall_i,
  output out_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  out_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0] count_d, count_q;
  logic            pop;

  assign pop     = valid_o & ~stall_i;
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == DepthCnt);
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store result words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Never push into a full queue
  `I2C_ASSERT(a_no_overflow, clk_i, rst_ni, push_i |-> (count_q < DepthCnt), "push into full result queue")
  // Occupancy stays within depth
  `I2C_ASSERT(a_count_range, clk_i, rst_ni, count_q <= DepthCnt, "result queue count out of range")
  // A push without a pop grows the queue by one word
  `I2C_ASSERT(a_count_push, clk_i, rst_ni, (push_i && !pop) |=> (count_q == $past(count_q) + CntW'(1)), "push did not grow queue")

endmodule

/* hdl/i2c_target_byte_engine.sv */
// I2C target byte engine: one SCL/SDA sample word in, one result word out.
// The result of an accepted sample is registered in the result queue and offered after earlier results.
// Throughput: one sample per cycle while the result queue has room; the bus state machine updates per accepted sample.
// Input stall rises only while the result queue (default two words) is full.
// Reset (rst_ni low, asynchronous) idles the bus state, empties the queue and
// loads register defaults: address 0x57, byte counts 1, transmit byte 0x55.
`timescale 1ns / 1ps

module i2c_target_byte_engine import i2c_tbe_pkg::*; #(
  parameter int unsigned OutDepth = OUTQ_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Sample channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  // Result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  // Configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t cfg;
  out_t result;
  logic accept;
  logic q_full;

  // Take a sample whenever the result queue has room
  assign in_stall_o  = q_full;
  assign accept      = in_valid_i & ~q_full;
  assign cfg_ready_o = 1'b1;

  i2c_tbe_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  i2c_tbe_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (in_data_i),
    .cfg_i    (cfg),
    .result_o (result)
  );

  i2c_tbe_outq #(
    .Depth (OutDepth)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (result),
    .full_o      (q_full),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .data_o      (out_data_o)
  );

endmodule
